// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cda_pkg.sv
// ---------------------------------------------------------------------------
// cda_pkg
// shared types, codes and month table for the calendar date adder
// ---------------------------------------------------------------------------
package cda_pkg;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int AMT_W    = 16;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 32;

    // months counter is one bit wider than the amount
    localparam int TOTAL_W   = AMT_W + 1;

    // quotient by three of a quartered month total: (x * RECIP_3) >> RECIP_SHIFT
    localparam logic [AMT_W-1:0] RECIP_3     = 16'd43691;
    localparam int               RECIP_SHIFT = 17;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MAX        = 16'hFFFF;

    // commands
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_YEARS  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MONTHS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DAYS   = 3'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic do_set;
        logic do_years;
        logic div_step;
        logic do_months;
        logic day_step;
        logic out_load;
    } cda_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             day_fin;
    } cda_sts_t;

    // fixed month lengths, no leap years; out-of-range months read 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: design/cda_ctrl.sv
// ---------------------------------------------------------------------------
// cda_ctrl
// command sequencer and handshake control for the date adder
// ---------------------------------------------------------------------------
module cda_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  cda_pkg::cda_sts_t   sts,
    output cda_pkg::cda_ctl_t   ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_MON    = 3'd3;
    localparam logic [2:0] S_DAYS   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic                      ovalid_reg, ovalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.cmd)
                    cda_pkg::CMD_SET:
                    begin
                        ctl.do_set = 1'b1;
                        state_next = S_FIN;
                    end
                    cda_pkg::CMD_YEARS:
                    begin
                        ctl.do_years = 1'b1;
                        state_next   = S_FIN;
                    end
                    cda_pkg::CMD_MONTHS:
                    begin
                        state_next = S_DIV;
                    end
                    cda_pkg::CMD_DAYS:
                    begin
                        state_next = S_DAYS;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                state_next   = S_MON;
            end
            S_MON:
            begin
                ctl.do_months = 1'b1;
                state_next    = S_FIN;
            end
            S_DAYS:
            begin
                ctl.day_step = 1'b1;
                if (sts.day_fin)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ctl.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// File: design/cda_dp.sv
// ---------------------------------------------------------------------------
// cda_dp
// date registers, month divider and day stepper
// ---------------------------------------------------------------------------
module cda_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cda_pkg::IN_W-1:0]    s_tdata,
    output logic [cda_pkg::OUT_W-1:0]   m_tdata,
    input  cda_pkg::cda_ctl_t           ctl,
    output cda_pkg::cda_sts_t           sts
);

    localparam int YW = cda_pkg::YEAR_W;
    localparam int MW = cda_pkg::MONTH_W;
    localparam int DW = cda_pkg::DAY_W;
    localparam int AW = cda_pkg::AMT_W;
    localparam int TW = cda_pkg::TOTAL_W;
    localparam int SW = cda_pkg::STATUS_W;
    localparam int PW = TW + AW - 2;

    // input word fields
    logic [cda_pkg::CMD_W-1:0] in_cmd;
    logic [AW-1:0]             in_amt;
    logic [YW-1:0]             in_sy;
    logic [MW-1:0]             in_sm;
    logic [DW-1:0]             in_sd;

    assign in_cmd = s_tdata[2:0];
    assign in_amt = s_tdata[18:3];
    assign in_sy  = s_tdata[34:19];
    assign in_sm  = s_tdata[38:35];
    assign in_sd  = s_tdata[43:39];

    // captured item
    logic [cda_pkg::CMD_W-1:0] cmd_reg;
    logic [AW-1:0]             amt_reg;
    logic [YW-1:0]             sy_reg;
    logic [MW-1:0]             sm_reg;
    logic [DW-1:0]             sd_reg;

    // date state
    logic [YW-1:0] year_reg,  year_next;
    logic [MW-1:0] month_reg, month_next;
    logic [DW-1:0] day_reg,   day_next;
    logic [DW-1:0] mlen_reg,  mlen_next;

    // work registers
    logic [AW-1:0] n_reg,   n_next;
    logic          sat_reg, sat_next;
    logic [SW-1:0] stat_reg, stat_next;
    logic [TW-1:0] div_reg, div_next;
    logic [MW-1:0] rem_reg, rem_next;

    logic [cda_pkg::OUT_W-1:0] out_reg;

    // combinational helpers
    logic            set_ok;
    logic [YW:0]     yr_sum;
    logic [YW+1:0]   mon_sum;
    logic [TW-3:0]   quo_x;
    logic [PW-1:0]   quo_prod;
    logic [TW-1:0]   quo;
    logic [MW-1:0]   quo_x12;
    logic [MW-1:0]   new_month;
    logic [DW-1:0]   new_len;
    logic [DW-1:0]   room;
    logic            fits;
    logic [MW-1:0]   wrap_month;
    logic            wrap_year;

    function automatic logic in_sm_chk(input logic [MW-1:0] m);
        return (m != '0) && (m <= cda_pkg::MONTHS_PER_YEAR);
    endfunction

    assign set_ok = (in_sm_chk(sm_reg)) && (sd_reg != '0) &&
                    (sd_reg <= cda_pkg::month_len(sm_reg));

    // total / 12 = (total / 4) / 3, the divide by three by reciprocal
    assign quo_x     = div_reg[TW-1:2];
    assign quo_prod  = {{AW{1'b0}}, quo_x} * {{(TW-2){1'b0}}, cda_pkg::RECIP_3};
    assign quo       = TW'(quo_prod[PW-1:cda_pkg::RECIP_SHIFT]);
    // low bits of 12 * quotient, enough for a remainder below twelve
    assign quo_x12   = {quo[1:0], 2'b00} + {quo[0], 3'b000};

    assign yr_sum    = {1'b0, year_reg} + {1'b0, amt_reg};
    assign mon_sum   = {2'b0, year_reg} + {1'b0, div_reg};
    assign new_month = rem_reg + 1'b1;
    assign new_len   = cda_pkg::month_len(new_month);
    assign room      = (mlen_reg > day_reg) ? (mlen_reg - day_reg) : '0;
    assign fits      = n_reg <= {{(AW-DW){1'b0}}, room};
    assign wrap_year = (month_reg == cda_pkg::MONTHS_PER_YEAR);
    assign wrap_month = wrap_year ? MW'(1) : (month_reg + 1'b1);

    assign sts.cmd     = cmd_reg;
    assign sts.day_fin = fits;

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        mlen_next  = mlen_reg;
        n_next     = n_reg;
        sat_next   = sat_reg;
        stat_next  = stat_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;

        if (ctl.capture)
        begin
            n_next    = in_amt;
            sat_next  = 1'b0;
            stat_next = cda_pkg::ST_OK;
            div_next  = {{(TW-MW){1'b0}}, month_reg - 1'b1} + {1'b0, in_amt};
            rem_next  = '0;
        end

        if (ctl.do_set)
        begin
            if (set_ok)
            begin
                year_next  = sy_reg;
                month_next = sm_reg;
                day_next   = sd_reg;
                mlen_next  = cda_pkg::month_len(sm_reg);
            end
            else
            begin
                stat_next = cda_pkg::ST_REJ;
            end
        end

        if (ctl.do_years)
        begin
            if (yr_sum[YW])
            begin
                year_next = cda_pkg::YEAR_MAX;
                stat_next = cda_pkg::ST_SAT;
            end
            else
            begin
                year_next = yr_sum[YW-1:0];
            end
        end

        // month total split into years and month index in one step
        if (ctl.div_step)
        begin
            rem_next = div_reg[MW-1:0] - quo_x12;
            div_next = quo;
        end

        if (ctl.do_months)
        begin
            if (mon_sum[YW+1:YW] != 2'b00)
            begin
                year_next = cda_pkg::YEAR_MAX;
                stat_next = cda_pkg::ST_SAT;
            end
            else
            begin
                year_next = mon_sum[YW-1:0];
            end
            month_next = new_month;
            mlen_next  = new_len;
            if (day_reg > new_len)
            begin
                day_next = new_len;
            end
        end

        // one month of the day count per step
        if (ctl.day_step)
        begin
            if (fits)
            begin
                day_next  = day_reg + n_reg[DW-1:0];
                stat_next = sat_reg ? cda_pkg::ST_SAT : cda_pkg::ST_OK;
            end
            else
            begin
                n_next     = n_reg - {{(AW-DW){1'b0}}, room} - 1'b1;
                day_next   = DW'(1);
                month_next = wrap_month;
                mlen_next  = cda_pkg::month_len(wrap_month);
                if (wrap_year)
                begin
                    if (year_reg == cda_pkg::YEAR_MAX)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        year_next = year_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= '0;
            month_reg <= MW'(1);
            day_reg   <= DW'(1);
            mlen_reg  <= DW'(31);
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            mlen_reg  <= mlen_next;
        end
    end

    // payload and work registers, no reset
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        sat_reg  <= sat_next;
        stat_reg <= stat_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        if (ctl.capture)
        begin
            cmd_reg <= in_cmd;
            amt_reg <= in_amt;
            sy_reg  <= in_sy;
            sm_reg  <= in_sm;
            sd_reg  <= in_sd;
        end
        if (ctl.out_load)
        begin
            out_reg <= {5'b0, stat_reg, day_reg, month_reg, year_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

// File: design/calendar_date_adder.sv
// set, add years and read: decode, then the result register loads and m_tvalid rises
// add months: decode, divide by twelve by reciprocal, month update, result load
// add days: decode, then the day stepper crosses one month per step, then result load
// throughput: one word in flight, a new word is taken the cycle after the result
// register loads, even while that result waits for the sink
// reset (rst_n low, async): date 0-01-01, no result pending
// ---------------------------------------------------------------------------
// calendar_date_adder
// leap-free calendar date counter with set, add and read commands
// ---------------------------------------------------------------------------
module calendar_date_adder
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input word
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // cmd[2:0], amount[18:3], set_year[34:19], set_month[38:35],
    // set_day[43:39], zero[47:44]
    input  logic [cda_pkg::IN_W-1:0]    s_tdata,
    // result word
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // year[15:0], month[19:16], day[24:20], status[26:25], zero[31:27]
    output logic [cda_pkg::OUT_W-1:0]   m_tdata
);

    // command bundle from sequencer, status bundle back from datapath
    cda_pkg::cda_ctl_t ctl;
    cda_pkg::cda_sts_t sts;

    // sequencer: decodes the captured command, paces the divider and
    // the day stepper, and owns the result-valid flag
    cda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath: date registers, divide-by-twelve for month adds,
    // month-at-a-time day stepper, output register
    cda_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .ctl     (ctl),
        .sts     (sts)
    );

endmodule

// File: design/cda_checker.sv
// ---------------------------------------------------------------------------
// cda_checker
// port-level checks for the calendar date adder, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cda_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cda_pkg::OUT_W-1:0]    m_tdata
);

    // a result word held back by the sink stays put
    `CDA_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one word at a time: input closes right after an accept
    `CDA_ASSERT_NXT(a_one_inflight, clk, rst_n, s_tvalid && s_tready, !s_tready, "input still open after accept")

    // reported month is always a real month
    `CDA_ASSERT_IMP(a_month_range, clk, rst_n, m_tvalid, (m_tdata[19:16] != 4'd0) && (m_tdata[19:16] <= 4'd12), "month out of range")

    // reported day is never zero and status code is defined
    `CDA_ASSERT_IMP(a_day_status, clk, rst_n, m_tvalid, (m_tdata[24:20] != 5'd0) && (m_tdata[26:25] != 2'd3), "bad day or status")

endmodule

bind calendar_date_adder cda_checker u_cda_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/calendar_date_adder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// calendar_date_adder_test
// self-checking bench for the leap-free calendar date adder: a queue-fed
// stream driver, a result monitor with random back-pressure and a
// date predictor that tracks the block's year, month and day
// ---------------------------------------------------------------------------
module calendar_date_adder_test;

    // command codes the package leaves out: read and the unused ones
    localparam logic [cda_pkg::CMD_W-1:0] CMD_READ     = 3'd4;
    localparam logic [cda_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [cda_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 100;
    localparam int RANDOM_WORDS = 81;
    localparam int REPORT_MAX   = 10;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]                     pad;
        logic [cda_pkg::DAY_W-1:0]      set_day;
        logic [cda_pkg::MONTH_W-1:0]    set_month;
        logic [cda_pkg::YEAR_W-1:0]     set_year;
        logic [cda_pkg::AMT_W-1:0]      amount;
        logic [cda_pkg::CMD_W-1:0]      cmd;
    } date_cmd_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [4:0]                     pad;
        logic [cda_pkg::STATUS_W-1:0]   status;
        logic [cda_pkg::DAY_W-1:0]      day;
        logic [cda_pkg::MONTH_W-1:0]    month;
        logic [cda_pkg::YEAR_W-1:0]     year;
    } date_res_t;

    logic                       clk;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // cmd, amount, set_year, set_month, set_day, zero pad
    logic [cda_pkg::IN_W-1:0]   s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // year, month, day, status, zero pad
    logic [cda_pkg::OUT_W-1:0]  m_tdata;

    // stimulus and scoreboard storage
    date_cmd_t  pending_words[$];
    date_res_t  expected_dates[$];
    date_cmd_t  on_bus;
    date_res_t  predicted;

    // predictor copy of the calendar
    int unsigned cal_year  = 0;
    int unsigned cal_month = 1;
    int unsigned cal_day   = 1;
    int unsigned cal_mlen  = 31;

    // idling control; idle percentages and hold request written by the stimulus process at the falling edge
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  hold_left;
    bit  hold_used;

    int  mismatches = 0;
    int  cycles     = 0;

    calendar_date_adder DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // date predictor
    // ---------------------------------------------------------------------

    // fixed table, no leap years; anything outside 1..12 reads as 31
    function automatic int unsigned days_in(input int unsigned m);
        case (m)
            2:             return 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // year stops at the top of its range and flags it
    task automatic bump_years(input int unsigned n, inout bit sat);
        int unsigned s;
        s = cal_year + n;
        if (s > 32'(cda_pkg::YEAR_MAX))
        begin
            cal_year = 32'(cda_pkg::YEAR_MAX);
            sat      = 1'b1;
        end
        else
            cal_year = s;
    endtask

    // month add carries into the year, then the day is clamped
    task automatic bump_months(input int unsigned n, inout bit sat);
        int unsigned total;
        total = (cal_month - 1) + n;
        bump_years(total / 32'(cda_pkg::MONTHS_PER_YEAR), sat);
        cal_month = total % 32'(cda_pkg::MONTHS_PER_YEAR) + 1;
        cal_mlen  = days_in(cal_month);
        if (cal_day > cal_mlen)
            cal_day = cal_mlen;
    endtask

    // day add walks month by month; december rolls into a 31-day january
    task automatic bump_days(input int unsigned n, inout bit sat);
        int unsigned room;
        while (n > 0)
        begin
            room = (cal_mlen > cal_day) ? cal_mlen - cal_day : 0;
            if (n <= room)
            begin
                cal_day += n;
                break;
            end
            n -= room + 1;
            cal_day = 1;
            bump_months(1, sat);
        end
    endtask

    task automatic apply_command(input date_cmd_t w, output date_res_t r);
        bit sat;
        bit rejected;
        sat      = 1'b0;
        rejected = 1'b0;
        case (w.cmd)
            cda_pkg::CMD_SET:
            begin
                if (w.set_month >= 1 && w.set_month <= cda_pkg::MONTHS_PER_YEAR
                    && w.set_day >= 1 && 32'(w.set_day) <= days_in(32'(w.set_month)))
                begin
                    cal_year  = 32'(w.set_year);
                    cal_month = 32'(w.set_month);
                    cal_day   = 32'(w.set_day);
                    cal_mlen  = days_in(32'(w.set_month));
                end
                else
                    rejected = 1'b1;
            end
            cda_pkg::CMD_YEARS:  bump_years(32'(w.amount), sat);
            cda_pkg::CMD_MONTHS: bump_months(32'(w.amount), sat);
            cda_pkg::CMD_DAYS:   bump_days(32'(w.amount), sat);
            default: ;           // read and the unused codes only report
        endcase
        r.pad    = '0;
        r.year   = cal_year[15:0];
        r.month  = cal_month[3:0];
        r.day    = cal_day[4:0];
        r.status = rejected ? cda_pkg::ST_REJ : (sat ? cda_pkg::ST_SAT : cda_pkg::ST_OK);
    endtask

    // ---------------------------------------------------------------------
    // driver: offers queued words, predicts each one when it is taken
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(on_bus, predicted);
                expected_dates.push_back(predicted);
            end
            // bus is free for a new word unless the current one is stalled
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // monitor: random back-pressure, compares each result in order
    // ---------------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endtask

    task automatic check_result(input date_res_t got);
        date_res_t want;
        if (expected_dates.size() == 0)
        begin
            log_mismatch($sformatf("unexpected result %0d-%0d-%0d status %0d",
                                   got.year, got.month, got.day, got.status));
            return;
        end
        want = expected_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day
            || got.status !== want.status || got.pad !== want.pad)
            log_mismatch($sformatf({"mismatch: expected %0d-%0d-%0d status %0d pad %0h, ",
                                    "got %0d-%0d-%0d status %0d pad %0h"},
                                   want.year, want.month, want.day, want.status, want.pad,
                                   got.year, got.month, got.day, got.status, got.pad));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    task automatic queue_word(input logic [2:0] cmd, input logic [15:0] amount,
                              input logic [15:0] y, input logic [3:0] m,
                              input logic [4:0] d);
        date_cmd_t w;
        w.pad       = '0;
        w.cmd       = cmd;
        w.amount    = amount;
        w.set_year  = y;
        w.set_month = m;
        w.set_day   = d;
        pending_words.push_back(w);
    endtask

    // mostly well-formed dates with random content, some junk sets,
    // day adds kept short except for a few very long ones
    task automatic queue_random(input int count);
        int          pick;
        int unsigned m;
        logic [15:0] y;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            y = ($urandom_range(9) < 3) ? 16'($urandom_range(65535, 65000))
                                        : 16'($urandom_range(65535));
            if (pick < 20)
            begin
                if ($urandom_range(4) != 0)
                begin
                    m = $urandom_range(12, 1);
                    queue_word(cda_pkg::CMD_SET, 16'($urandom_range(65535)), y, 4'(m),
                               5'($urandom_range(days_in(m), 1)));
                end
                else
                    queue_word(cda_pkg::CMD_SET, 16'($urandom_range(65535)), y,
                               4'($urandom_range(15)), 5'($urandom_range(31)));
            end
            else if (pick < 35)
                queue_word(cda_pkg::CMD_YEARS,
                           16'($urandom_range(1) ? $urandom_range(65535) : $urandom_range(20)),
                           y, 4'($urandom_range(15)), 5'($urandom_range(31)));
            else if (pick < 55)
                queue_word(cda_pkg::CMD_MONTHS,
                           16'($urandom_range(1) ? $urandom_range(65535) : $urandom_range(40)),
                           y, 4'($urandom_range(15)), 5'($urandom_range(31)));
            else if (pick < 88)
            begin
                pick = $urandom_range(99);
                queue_word(cda_pkg::CMD_DAYS,
                           16'((pick < 3)  ? $urandom_range(65535) :
                               (pick < 30) ? $urandom_range(2000) : $urandom_range(400)),
                           y, 4'($urandom_range(15)), 5'($urandom_range(31)));
            end
            else
                queue_word(3'($urandom_range(CMD_SPARE_HI, CMD_READ)),
                           16'($urandom_range(65535)),
                           y, 4'($urandom_range(15)), 5'($urandom_range(31)));
        end
    endtask

    // wait until every queued word is taken and every result is back
    task automatic drain;
        while (pending_words.size() != 0 || s_tvalid || expected_dates.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase one: sender idles a little, receiver a lot
        send_idle_pct = 13;
        recv_idle_pct = 72;

        // reset date read back, then simple day steps across january
        queue_word(CMD_READ, 16'hFFFF, 16'hFFFF, 4'hF, 5'h1F);
        queue_word(cda_pkg::CMD_DAYS, 16'd0, 16'd0, 4'd0, 5'd0);
        queue_word(cda_pkg::CMD_DAYS, 16'd30, 16'd0, 4'd0, 5'd0);
        queue_word(cda_pkg::CMD_DAYS, 16'd1, 16'd0, 4'd0, 5'd0);
        // last day of the last year, one more day saturates the year
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'hFFFF, 4'd12, 5'd31);
        queue_word(cda_pkg::CMD_DAYS, 16'd1, 16'd0, 4'd0, 5'd0);
        // rejected sets: bad months, day zero, day past the month's end, then a valid set
        queue_word(cda_pkg::CMD_SET, 16'hFFFF, 16'd1234, 4'd0, 5'd1);
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd1234, 4'd13, 5'd1);
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd1234, 4'd15, 5'd31);
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd1234, 4'd3, 5'd0);
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd1234, 4'd2, 5'd29);
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd1234, 4'd4, 5'd31);
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd0, 4'd2, 5'd28);
        // month add clamps the day, then carries into the next year
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd0, 4'd1, 5'd31);
        queue_word(cda_pkg::CMD_MONTHS, 16'd1, 16'd0, 4'd0, 5'd0);
        queue_word(cda_pkg::CMD_MONTHS, 16'd11, 16'd0, 4'd0, 5'd0);
        // december wraps to january, then large month and year adds
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd2000, 4'd12, 5'd15);
        queue_word(cda_pkg::CMD_MONTHS, 16'd1, 16'd0, 4'd0, 5'd0);
        queue_word(cda_pkg::CMD_MONTHS, 16'hFFFF, 16'd0, 4'd0, 5'd0);
        queue_word(cda_pkg::CMD_YEARS, 16'hFFFF, 16'd0, 4'd0, 5'd0);
        queue_word(cda_pkg::CMD_YEARS, 16'd0, 16'hFFFF, 4'hF, 5'h1F);
        // day roll from new year's eve must use january's length
        queue_word(cda_pkg::CMD_SET, 16'd0, 16'd0, 4'd12, 5'd31);
        queue_word(cda_pkg::CMD_DAYS, 16'd32, 16'd0, 4'd0, 5'd0);
        // longest day add, and the unused codes act as reads
        queue_word(cda_pkg::CMD_DAYS, 16'hFFFF, 16'd0, 4'd0, 5'd0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            queue_word(3'(c), 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       4'($urandom_range(15)), 5'($urandom_range(31)));

        queue_random(RANDOM_WORDS);
        drain();

        // phase two: roles swapped
        send_idle_pct = 72;
        recv_idle_pct = 13;
        queue_random(RANDOM_WORDS);
        drain();

        // phase three: no idling, plus the long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        queue_random(RANDOM_WORDS);
        drain();

        repeat (SETTLE_WAIT) @(negedge clk);
        if (mismatches == 0 && expected_dates.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/cda_pkg.sv
design/cda_ctrl.sv
design/cda_dp.sv
design/calendar_date_adder.sv
design/cda_checker.sv
bench/calendar_date_adder_test.sv
